// File: design/ptt_pkg.sv
// Package for the page table translator: sizes, derived widths, the page wrap table
// and the TLB control structs. No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int FRAME_COUNT = 128;
  localparam int PAGE_COUNT  = 256;

  localparam int VA_W    = 16;
  localparam int OFFS_W  = 8;
  localparam int VPN_W   = 8;
  localparam int PA_W    = 15;
  localparam int FNUM_W  = 7;

  localparam int TLB_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int VPN_NUM = 1 << VPN_W;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [TLB_W-1:0]   tlb_idx_t;

  typedef page_t page_lut_t [VPN_NUM];

  function automatic page_lut_t build_page_lut();
    page_lut_t lut;
    for (int i = 0; i < VPN_NUM; i++) begin
      lut[i] = PAGE_W'(i % PAGE_COUNT);
    end
    return lut;
  endfunction

  localparam page_lut_t PAGE_LUT = build_page_lut();

  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tlb_lkp_t;

  typedef struct packed {
    logic   fill;
    page_t  page;
    frame_t frame;
    logic   inval;
    frame_t inval_frame;
  } tlb_upd_t;

endpackage

`default_nettype wire

// File: design/ptt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/ptt_tlb.sv
// Fully associative TLB in flip-flops: priority lookup, frame invalidation and FIFO fill.
// Depends on ptt_pkg.
`default_nettype none

module ptt_tlb (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptt_pkg::page_t    lkp_page_i,
  output ptt_pkg::tlb_lkp_t lkp_o,
  input  ptt_pkg::tlb_upd_t upd_i
);

  logic                 valid_q [ptt_pkg::TLB_ENTRIES];
  ptt_pkg::page_t       page_q  [ptt_pkg::TLB_ENTRIES];
  ptt_pkg::frame_t      frame_q [ptt_pkg::TLB_ENTRIES];
  ptt_pkg::tlb_idx_t    ptr_q, ptr_d;

  always_comb begin
    lkp_o.hit   = 1'b0;
    lkp_o.frame = '0;
    for (int i = ptt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == lkp_page_i)) begin
        lkp_o.hit   = 1'b1;
        lkp_o.frame = frame_q[i];
      end
    end
  end

  always_comb begin
    if (ptr_q == ptt_pkg::tlb_idx_t'(ptt_pkg::TLB_ENTRIES - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + ptt_pkg::tlb_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < ptt_pkg::TLB_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        page_q[i]  <= '0;
        frame_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ptt_pkg::TLB_ENTRIES; i++) begin
        if (upd_i.fill && (ptr_q == ptt_pkg::tlb_idx_t'(i))) begin
          valid_q[i] <= 1'b1;
          page_q[i]  <= upd_i.page;
          frame_q[i] <= upd_i.frame;
        end else if (upd_i.inval && (frame_q[i] == upd_i.inval_frame)) begin
          valid_q[i] <= 1'b0;
        end
      end
      if (upd_i.fill) begin
        ptr_q <= ptr_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/tlb_page_table_translator_top.sv
// Top level of the page table translator: input stage, page table and reverse map
// memories, TLB and result register. Depends on ptt_pkg, ptt_ram and ptt_tlb.
//
//   channel | direction | handshake                 | payload
//   input   | in        | in_valid_i / in_ready_o   | virtual_address_i
//   result  | out       | out_valid_o / out_ready_i | physical_address_o, frame_number_o,
//           |           |                           | tlb_hit_o, page_fault_o
//
// One transaction per cycle sustained while the result register drains; the page table
// memory is read as an address enters the input stage, then lookup and state update follow.
// A held result stalls the input stage only when the result register cannot drain.
// Reset clears the TLB, page valid bits, the frame owner wrap flag and both pointers at
// once; no clearing pass is needed.
`default_nettype none

module tlb_page_table_translator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ptt_pkg::VA_W-1:0]     virtual_address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ptt_pkg::PA_W-1:0]     physical_address_o,
  output logic [ptt_pkg::FNUM_W-1:0]   frame_number_o,
  output logic                         tlb_hit_o,
  output logic                         page_fault_o
);

  logic                              s1_valid_q;
  ptt_pkg::page_t                    s1_page_q;
  logic [ptt_pkg::OFFS_W-1:0]        s1_offset_q;

  logic                              page_valid_q [ptt_pkg::PAGE_COUNT];
  logic                              owner_wrap_q;
  ptt_pkg::frame_t                   victim_q, victim_d, victim_inc;

  logic                              fwd_valid_q;
  ptt_pkg::page_t                    fwd_page_q;
  ptt_pkg::frame_t                   fwd_frame_q;

  logic                              out_valid_q;
  logic [ptt_pkg::PA_W-1:0]          pa_q;
  logic [ptt_pkg::FNUM_W-1:0]        fnum_q;
  logic                              hit_q;
  logic                              fault_q;

  logic                              accept;
  logic                              advance;
  ptt_pkg::page_t                    in_page;
  ptt_pkg::frame_t                   pf_rdata;
  ptt_pkg::page_t                    owner_rdata;
  ptt_pkg::frame_t                   pt_frame;
  ptt_pkg::frame_t                   frame;
  logic [7:0]                        frame_ext;
  logic                              miss;
  logic                              fault;
  ptt_pkg::tlb_lkp_t                 lkp;
  ptt_pkg::tlb_upd_t                 upd;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign in_page    = ptt_pkg::PAGE_LUT[virtual_address_i[ptt_pkg::VA_W-1:ptt_pkg::OFFS_W]];

  ptt_tlb u_tlb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lkp_page_i (s1_page_q),
    .lkp_o      (lkp),
    .upd_i      (upd)
  );

  ptt_ram #(
    .WIDTH (ptt_pkg::FRAME_W),
    .DEPTH (ptt_pkg::PAGE_COUNT)
  ) u_page_frame (
    .clk_i   (clk_i),
    .we_i    (advance && fault),
    .waddr_i (s1_page_q),
    .wdata_i (victim_q),
    .re_i    (accept),
    .raddr_i (in_page),
    .rdata_o (pf_rdata)
  );

  ptt_ram #(
    .WIDTH (ptt_pkg::PAGE_W),
    .DEPTH (ptt_pkg::FRAME_COUNT)
  ) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (advance && fault),
    .waddr_i (victim_q),
    .wdata_i (s1_page_q),
    .re_i    (1'b1),
    .raddr_i (victim_d),
    .rdata_o (owner_rdata)
  );

  always_comb begin
    if (victim_q == ptt_pkg::frame_t'(ptt_pkg::FRAME_COUNT - 1)) begin
      victim_inc = '0;
    end else begin
      victim_inc = victim_q + ptt_pkg::frame_t'(1);
    end
    victim_d = (advance && fault) ? victim_inc : victim_q;
  end

  always_comb begin
    miss     = !lkp.hit;
    fault    = miss && !page_valid_q[s1_page_q];
    pt_frame = (fwd_valid_q && (fwd_page_q == s1_page_q)) ? fwd_frame_q : pf_rdata;
    priority if (lkp.hit) begin
      frame = lkp.frame;
    end else if (fault) begin
      frame = victim_q;
    end else begin
      frame = pt_frame;
    end
    frame_ext = 8'(frame);

    upd.fill        = advance && miss;
    upd.page        = s1_page_q;
    upd.frame       = frame;
    upd.inval       = advance && fault;
    upd.inval_frame = victim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_page_q    <= '0;
      s1_offset_q  <= '0;
      victim_q     <= '0;
      owner_wrap_q <= 1'b0;
      fwd_valid_q  <= 1'b0;
      fwd_page_q   <= '0;
      fwd_frame_q  <= '0;
      out_valid_q  <= 1'b0;
      pa_q         <= '0;
      fnum_q       <= '0;
      hit_q        <= 1'b0;
      fault_q      <= 1'b0;
      for (int i = 0; i < ptt_pkg::PAGE_COUNT; i++) begin
        page_valid_q[i] <= 1'b0;
      end
    end else begin
      if (accept) begin
        s1_page_q   <= in_page;
        s1_offset_q <= virtual_address_i[ptt_pkg::OFFS_W-1:0];
        fwd_valid_q <= advance && fault;
        fwd_page_q  <= s1_page_q;
        fwd_frame_q <= victim_q;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end

      victim_q <= victim_d;
      if (advance && fault) begin
        if (victim_q == ptt_pkg::frame_t'(ptt_pkg::FRAME_COUNT - 1)) begin
          owner_wrap_q <= 1'b1;
        end
        for (int i = 0; i < ptt_pkg::PAGE_COUNT; i++) begin
          if (s1_page_q == ptt_pkg::page_t'(i)) begin
            page_valid_q[i] <= 1'b1;
          end else if (owner_wrap_q && (owner_rdata == ptt_pkg::page_t'(i))) begin
            page_valid_q[i] <= 1'b0;
          end
        end
      end

      if (advance) begin
        out_valid_q <= 1'b1;
        pa_q        <= {frame_ext[ptt_pkg::FNUM_W-1:0], s1_offset_q};
        fnum_q      <= frame_ext[ptt_pkg::FNUM_W-1:0];
        hit_q       <= lkp.hit;
        fault_q     <= fault;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = pa_q;
  assign frame_number_o     = fnum_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;

endmodule

`default_nettype wire

// File: sim/tb_tlb_page_table_translator_top.sv
// Testbench for tlb_page_table_translator_top: a directed address table, then biased random
// addresses, each checked against a fixed table result or an in-bench model of the TLB,
// page table and frame owners. Depends on ptt_pkg and the design sources; reads no files.
`default_nettype none

module tb_tlb_page_table_translator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 1400;
  localparam int HOLD_CYC   = 100;

  typedef struct packed {
    logic [ptt_pkg::PA_W-1:0]   pa;
    logic [ptt_pkg::FNUM_W-1:0] frame;
    logic                       hit;
    logic                       fault;
  } xlat_t;

  typedef struct {
    logic [ptt_pkg::VA_W-1:0] va;
    bit                       typed;
    xlat_t                    want;
  } dir_row_t;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic [ptt_pkg::VA_W-1:0]   va         = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic [ptt_pkg::PA_W-1:0]   pa;
  logic [ptt_pkg::FNUM_W-1:0] fnum;
  logic                       hit;
  logic                       fault;

  tlb_page_table_translator_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .virtual_address_i  (va),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .physical_address_o (pa),
    .frame_number_o     (fnum),
    .tlb_hit_o          (hit),
    .page_fault_o       (fault)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // translation model state
  logic              pt_valid [ptt_pkg::PAGE_COUNT];
  ptt_pkg::frame_t   pt_frame [ptt_pkg::PAGE_COUNT];
  logic              tlb_v    [ptt_pkg::TLB_ENTRIES];
  ptt_pkg::page_t    tlb_vpn  [ptt_pkg::TLB_ENTRIES];
  ptt_pkg::frame_t   tlb_pfn  [ptt_pkg::TLB_ENTRIES];
  ptt_pkg::tlb_idx_t fill_ptr;
  ptt_pkg::frame_t   victim_ptr;
  logic              owner_v  [ptt_pkg::FRAME_COUNT];
  ptt_pkg::page_t    owner_pg [ptt_pkg::FRAME_COUNT];

  xlat_t pending_xlat [$];
  int    err_cnt    = 0;
  int    sent_cnt   = 0;
  int    got_cnt    = 0;
  int    hit_cnt    = 0;
  int    fault_cnt  = 0;
  int    evict_cnt  = 0;
  int    refill_cnt = 0;
  bit    hold_req   = 1'b0;

  logic [7:0] hot_pages [6];
  logic [7:0] win_base;

  dir_row_t dir_rows [24] = '{
    '{16'h0000, 1'b1, '{15'h0000, 7'd0, 1'b0, 1'b1}},
    '{16'hFFFF, 1'b1, '{15'h01FF, 7'd1, 1'b0, 1'b1}},
    '{16'h00FF, 1'b1, '{15'h00FF, 7'd0, 1'b1, 1'b0}},
    '{16'hFF00, 1'b1, '{15'h0100, 7'd1, 1'b1, 1'b0}},
    '{16'h8001, 1'b1, '{15'h0201, 7'd2, 1'b0, 1'b1}},
    '{16'h7F80, 1'b1, '{15'h0380, 7'd3, 1'b0, 1'b1}},
    '{16'h0111, 1'b0, '0},
    '{16'h0222, 1'b0, '0},
    '{16'h0333, 1'b0, '0},
    '{16'h0444, 1'b0, '0},
    '{16'h0555, 1'b0, '0},
    '{16'h0666, 1'b0, '0},
    '{16'h0777, 1'b0, '0},
    '{16'h0888, 1'b0, '0},
    '{16'h0999, 1'b0, '0},
    '{16'h0AAA, 1'b0, '0},
    '{16'h0BBB, 1'b0, '0},
    '{16'h0CCC, 1'b0, '0},
    '{16'h0DDD, 1'b0, '0},
    '{16'h0042, 1'b0, '0},
    '{16'h5A5A, 1'b0, '0},
    '{16'hA5A5, 1'b0, '0},
    '{16'h0FF0, 1'b0, '0},
    '{16'hFFFE, 1'b0, '0}
  };

  function automatic void clear_model();
    for (int i = 0; i < ptt_pkg::PAGE_COUNT; i++) begin
      pt_valid[i] = 1'b0;
      pt_frame[i] = '0;
    end
    for (int i = 0; i < ptt_pkg::TLB_ENTRIES; i++) begin
      tlb_v[i]   = 1'b0;
      tlb_vpn[i] = '0;
      tlb_pfn[i] = '0;
    end
    for (int i = 0; i < ptt_pkg::FRAME_COUNT; i++) begin
      owner_v[i]  = 1'b0;
      owner_pg[i] = '0;
    end
    fill_ptr   = '0;
    victim_ptr = '0;
  endfunction

  function automatic xlat_t translate(input logic [ptt_pkg::VA_W-1:0] addr);
    ptt_pkg::page_t  pg;
    ptt_pkg::frame_t fr;
    xlat_t           r;
    logic            found;
    pg    = ptt_pkg::page_t'(int'(addr[ptt_pkg::VA_W-1:ptt_pkg::OFFS_W]) % ptt_pkg::PAGE_COUNT);
    found = 1'b0;
    fr    = '0;
    r     = '0;
    for (int i = 0; i < ptt_pkg::TLB_ENTRIES; i++) begin
      if (!found && tlb_v[i] && tlb_vpn[i] == pg) begin
        found = 1'b1;
        fr    = tlb_pfn[i];
      end
    end
    r.hit = found;
    if (!found) begin
      if (!pt_valid[pg]) begin
        fr = victim_ptr;
        if (owner_v[fr]) begin
          pt_valid[owner_pg[fr]] = 1'b0;
          evict_cnt++;
        end
        owner_v[fr] = 1'b0;
        for (int i = 0; i < ptt_pkg::TLB_ENTRIES; i++) begin
          if (tlb_pfn[i] == fr) tlb_v[i] = 1'b0;
        end
        victim_ptr   = ptt_pkg::frame_t'((int'(fr) + 1) % ptt_pkg::FRAME_COUNT);
        pt_valid[pg] = 1'b1;
        pt_frame[pg] = fr;
        owner_v[fr]  = 1'b1;
        owner_pg[fr] = pg;
        r.fault      = 1'b1;
      end else begin
        refill_cnt++;
      end
      fr                = pt_frame[pg];
      tlb_vpn[fill_ptr] = pg;
      tlb_pfn[fill_ptr] = fr;
      tlb_v[fill_ptr]   = 1'b1;
      fill_ptr          = ptt_pkg::tlb_idx_t'((int'(fill_ptr) + 1) % ptt_pkg::TLB_ENTRIES);
    end
    hit_cnt   += r.hit;
    fault_cnt += r.fault;
    r.frame = ptt_pkg::FNUM_W'(fr);
    r.pa    = ptt_pkg::PA_W'({fr, addr[ptt_pkg::OFFS_W-1:0]});
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [ptt_pkg::VA_W-1:0] gen_addr();
    int         m;
    logic [7:0] pg;
    m = $urandom_range(0, 9);
    if (m < 5) pg = hot_pages[$urandom_range(0, 5)];
    else if (m < 8) pg = 8'(win_base + $urandom_range(0, 39));
    else pg = 8'($urandom);
    return {pg, 8'($urandom)};
  endfunction

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send(input logic [ptt_pkg::VA_W-1:0] addr, input xlat_t want);
    in_valid <= 1'b1;
    va       <= addr;
    do @(posedge clk_i); while (!in_ready);
    pending_xlat.push_back(want);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic rest(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    rest(1);
    while (pending_xlat.size() != 0) @(negedge clk_i);
  endtask

  task automatic cmp(input string name, input int e, input int g);
    if (e != g) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, e, g);
    end
  endtask

  always @(posedge clk_i) begin
    xlat_t e;
    if (rst_ni && out_valid && out_ready) begin
      got_cnt++;
      if (pending_xlat.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, got pa=0x%0h frame=%0d hit=%0b fault=%0b",
                 $time, pa, fnum, hit, fault);
      end else begin
        e = pending_xlat.pop_front();
        cmp("physical_address", e.pa, pa);
        cmp("frame_number", e.frame, fnum);
        cmp("tlb_hit", e.hit, hit);
        cmp("page_fault", e.fault, fault);
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b1;
        repeat (40) @(negedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("%0t: timeout with %0d results outstanding", $time, pending_xlat.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    xlat_t                    pred;
    logic [ptt_pkg::VA_W-1:0] addr;
    int                       gap;
    int                       burst;
    burst = 0;
    clear_model();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      pred = translate(dir_rows[i].va);
      send(dir_rows[i].va, dir_rows[i].typed ? dir_rows[i].want : pred);
      gap = pick_gap();
      if (gap > 0) rest(gap);
    end

    win_base = 8'($urandom);
    foreach (hot_pages[k]) hot_pages[k] = 8'($urandom);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 50 == 0) hot_pages[$urandom_range(0, 5)] = 8'($urandom);
      if (i % 150 == 0) win_base = 8'(win_base + $urandom_range(8, 60));
      if (i == 400) begin
        hold_req = 1'b1;
        burst    = 40;
      end
      if (i == 800) drain();
      addr = gen_addr();
      pred = translate(addr);
      send(addr, pred);
      if (burst > 0) begin
        burst--;
      end else begin
        gap = pick_gap();
        if (gap > 0) rest(gap);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d addresses, got %0d results: %0d TLB hits, %0d refills from the table,",
             sent_cnt, got_cnt, hit_cnt, refill_cnt);
    $display("%0d page faults of which %0d evicted a resident page; %0d mismatches.",
             fault_cnt, evict_cnt, err_cnt);
    if (err_cnt == 0 && pending_xlat.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/ptt_pkg.sv
design/ptt_ram.sv
design/ptt_tlb.sv
design/tlb_page_table_translator_top.sv
sim/tb_tlb_page_table_translator_top.sv
